// ===== rtl/core/csl_pkg.sv =====
// Shared widths, codes and the token record of the C subset lexer.
package csl_pkg;

   localparam int OFFSET_BITS = 20;
   localparam int LINE_BITS = 16;
   localparam int LEN_BITS = 8;
   localparam int CH_BITS = 8;
   localparam int KIND_BITS = 4;
   localparam int KW_BITS = 48;

   // Response tdata: line_no, start_offset, tok_len, zero filled to whole bytes
   localparam int PAYLOAD_BITS = LINE_BITS + OFFSET_BITS + LEN_BITS;
   localparam int RSP_DATA_BITS = ((PAYLOAD_BITS + 7) / 8) * 8;
   localparam int PAD_BITS = RSP_DATA_BITS - PAYLOAD_BITS;

   // Token queue: power-of-two depth, at least four
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_EOF     = 4'd0,
      KIND_ASSIGN  = 4'd1,
      KIND_BCOM    = 4'd2,
      KIND_LBRACE  = 4'd3,
      KIND_LPAREN  = 4'd4,
      KIND_RBRACE  = 4'd5,
      KIND_RPAREN  = 4'd6,
      KIND_SEMI    = 4'd7,
      KIND_DECR    = 4'd8,
      KIND_NEG     = 4'd9,
      KIND_INT     = 4'd10,
      KIND_VOID    = 4'd11,
      KIND_RETURN  = 4'd12,
      KIND_ID      = 4'd13,
      KIND_NUM     = 4'd14,
      KIND_INVALID = 4'd15
   } kind_type;

   typedef enum logic [8:0] {
      MODE_IDLE  = 9'b000000001,
      MODE_SLASH = 9'b000000010,
      MODE_LCOM  = 9'b000000100,
      MODE_BCOM  = 9'b000001000,
      MODE_BSTAR = 9'b000010000,
      MODE_MINUS = 9'b000100000,
      MODE_IDENT = 9'b001000000,
      MODE_NUM   = 9'b010000000,
      MODE_ERR   = 9'b100000000
   } mode_type;

   typedef struct packed {
      kind_type                kind;
      logic [LINE_BITS-1:0]    line_no;
      logic [OFFSET_BITS-1:0]  start_offset;
      logic [LEN_BITS-1:0]     tok_len;
      logic                    last;
   } token_type;

endpackage

// ===== rtl/core/c_subset_lexer.sv =====
// Top level of the C subset lexer: input byte register, scanner and token queue.
//
//   channel | direction | tdata                                  | tuser | tlast
//   req_    | in        | ch [7:0]                               | -     | -
//   rsp_    | out       | line_no, start_offset, tok_len, zeros  | kind  | last
//
// One byte per cycle while the queue has room: a byte is held in the input
// register, is scanned and its tokens are written to a four-entry queue; a
// token is offered on rsp_ once it is in the queue's registers. The queue
// drains one token per cycle while rsp_tready is high, so a byte that closes
// one token and starts another leaves an extra token to drain. The input
// register holds its byte while the queue has more than two tokens. Reset gives
// line 1, offset 0, an empty queue and no waiting byte.
module c_subset_lexer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [csl_pkg::CH_BITS-1:0]           req_tdata,   // ch
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // line_no, start_offset, tok_len, zero fill (lowest bit first)
   output logic [csl_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic [csl_pkg::KIND_BITS-1:0]         rsp_tuser,   // kind
   output logic                                  rsp_tlast
);
   import csl_pkg::*;

   logic [CH_BITS-1:0]  ch_ff, ch_in;
   logic                in_valid_ff, in_valid_in;
   logic                consume;
   logic                req_xfer;
   logic                tok0_valid;
   logic                tok1_valid;
   token_type           tok0;
   token_type           tok1;
   token_type           head;
   logic [CNT_BITS-1:0] count;

   // Scan the held byte once the queue has room for two tokens
   assign consume    = in_valid_ff && (count <= CNT_BITS'(FIFO_DEPTH - 2));
   assign req_tready = !in_valid_ff || consume;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      ch_in       = req_xfer ? req_tdata : ch_ff;
      in_valid_in = req_xfer || (in_valid_ff && !consume);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
   end

   csl_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step_en    (consume),
      .ch         (ch_ff),
      .tok0_valid (tok0_valid),
      .tok1_valid (tok1_valid),
      .tok0       (tok0),
      .tok1       (tok1)
   );

   csl_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push0 (consume && tok0_valid),
      .push1 (consume && tok1_valid),
      .din0  (tok0),
      .din1  (tok1),
      .pop   (rsp_tvalid && rsp_tready),
      .dout  (head),
      .count (count)
   );

   // Present the queue head
   assign rsp_tvalid = (count != '0);
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, head.tok_len, head.start_offset, head.line_no};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset) count <= CNT_BITS'(FIFO_DEPTH))
      else $error("token queue overflow");

   // A second token only follows a first one
   assert property (@(posedge clock) disable iff (reset) tok1_valid |-> tok0_valid)
      else $error("second token without first");

   // End of text always yields a token
   assert property (@(posedge clock) disable iff (reset)
      (consume && ch_ff == '0) |=> rsp_tvalid)
      else $error("zero byte gave no token");

   // Nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("token offered after reset");

endmodule

// ===== rtl/core/csl_scan.sv =====
// Lexer state and the per-byte scan logic that yields up to two tokens.
module csl_scan (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic [csl_pkg::CH_BITS-1:0]    ch,
   output logic                           tok0_valid,
   output logic                           tok1_valid,
   output csl_pkg::token_type             tok0,
   output csl_pkg::token_type             tok1
);
   import csl_pkg::*;

   localparam logic [CH_BITS-1:0] CH_NUL    = 8'h00;
   localparam logic [CH_BITS-1:0] CH_TAB    = 8'h09;
   localparam logic [CH_BITS-1:0] CH_NL     = 8'h0a;
   localparam logic [CH_BITS-1:0] CH_VT     = 8'h0b;
   localparam logic [CH_BITS-1:0] CH_FF     = 8'h0c;
   localparam logic [CH_BITS-1:0] CH_CR     = 8'h0d;
   localparam logic [CH_BITS-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_BITS-1:0] CH_LPAREN = 8'h28;
   localparam logic [CH_BITS-1:0] CH_RPAREN = 8'h29;
   localparam logic [CH_BITS-1:0] CH_STAR   = 8'h2a;
   localparam logic [CH_BITS-1:0] CH_MINUS  = 8'h2d;
   localparam logic [CH_BITS-1:0] CH_SLASH  = 8'h2f;
   localparam logic [CH_BITS-1:0] CH_SEMI   = 8'h3b;
   localparam logic [CH_BITS-1:0] CH_ASSIGN = 8'h3d;
   localparam logic [CH_BITS-1:0] CH_USCORE = 8'h5f;
   localparam logic [CH_BITS-1:0] CH_LBRACE = 8'h7b;
   localparam logic [CH_BITS-1:0] CH_RBRACE = 8'h7d;
   localparam logic [CH_BITS-1:0] CH_TILDE  = 8'h7e;

   localparam logic [KW_BITS-1:0] KW_INT    = 48'h0000_0074_6E69;
   localparam logic [KW_BITS-1:0] KW_VOID   = 48'h0000_6469_6F76;
   localparam logic [KW_BITS-1:0] KW_RETURN = 48'h6E72_7574_6572;
   localparam int KW_CHARS = KW_BITS / CH_BITS;

   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
   localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;

   // Outcome of a byte seen between tokens
   typedef struct packed {
      logic     tok_v;
      kind_type kind;
      logic     eof;
      logic     bump;
      logic     start;
      logic     load_kw;
      mode_type nmode;
   } idle_type;

   function automatic logic is_letter(input logic [CH_BITS-1:0] c);
      return (c inside {[8'h61:8'h7a], [8'h41:8'h5a]}) || (c == CH_USCORE);
   endfunction

   function automatic logic is_digit(input logic [CH_BITS-1:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_space(input logic [CH_BITS-1:0] c);
      return c inside {CH_SPACE, CH_FF, CH_NL, CH_CR, CH_TAB, CH_VT};
   endfunction

   function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
      return (v == LEN_MAX) ? v : v + LEN_BITS'(1);
   endfunction

   function automatic idle_type idle_eval(input logic [CH_BITS-1:0] c);
      idle_type r;
      r         = '0;
      r.kind    = KIND_EOF;
      r.nmode   = MODE_IDLE;
      if (c == CH_NUL) begin
         r.tok_v = 1'b1;
         r.eof   = 1'b1;
      end else if (is_space(c)) begin
         r.bump = (c == CH_NL);
      end else begin
         case (c)
            CH_ASSIGN: begin r.tok_v = 1'b1; r.kind = KIND_ASSIGN; end
            CH_TILDE:  begin r.tok_v = 1'b1; r.kind = KIND_BCOM;   end
            CH_LBRACE: begin r.tok_v = 1'b1; r.kind = KIND_LBRACE; end
            CH_LPAREN: begin r.tok_v = 1'b1; r.kind = KIND_LPAREN; end
            CH_RBRACE: begin r.tok_v = 1'b1; r.kind = KIND_RBRACE; end
            CH_RPAREN: begin r.tok_v = 1'b1; r.kind = KIND_RPAREN; end
            CH_SEMI:   begin r.tok_v = 1'b1; r.kind = KIND_SEMI;   end
            default: begin
               r.start = 1'b1;
               if (c == CH_SLASH) begin
                  r.nmode = MODE_SLASH;
               end else if (c == CH_MINUS) begin
                  r.nmode = MODE_MINUS;
               end else if (is_digit(c)) begin
                  r.nmode = MODE_NUM;
               end else if (is_letter(c)) begin
                  r.nmode   = MODE_IDENT;
                  r.load_kw = 1'b1;
               end else begin
                  r.nmode = MODE_ERR;
                  r.tok_v = 1'b1;
                  r.kind  = KIND_INVALID;
               end
            end
         endcase
      end
      return r;
   endfunction

   mode_type               mode_ff, mode_in;
   logic [KW_BITS-1:0]     kw_ff, kw_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;

   idle_type            idle;
   logic                use_idle;
   logic                bump;
   logic                eof;
   logic                pre_v;
   kind_type            pre_kind;
   logic [LEN_BITS-1:0] pre_len;
   logic                post_v;
   kind_type            post_kind;
   logic [LEN_BITS-1:0] post_len;
   kind_type            ident_kind;

   // Classify a finished identifier against the keywords
   always_comb begin
      if (len_ff == LEN_BITS'(3) && kw_ff == KW_INT) begin
         ident_kind = KIND_INT;
      end else if (len_ff == LEN_BITS'(4) && kw_ff == KW_VOID) begin
         ident_kind = KIND_VOID;
      end else if (len_ff == LEN_BITS'(6) && kw_ff == KW_RETURN) begin
         ident_kind = KIND_RETURN;
      end else begin
         ident_kind = KIND_ID;
      end
   end

   // Scan one byte: pre token closes the pending token, post token comes from this byte
   always_comb begin
      idle      = idle_eval(ch);
      use_idle  = 1'b0;
      bump      = 1'b0;
      eof       = 1'b0;
      pre_v     = 1'b0;
      pre_kind  = KIND_INVALID;
      pre_len   = len_ff;
      post_v    = 1'b0;
      post_kind = KIND_EOF;
      post_len  = '0;
      mode_in   = mode_ff;
      kw_in     = kw_ff;
      start_in  = start_ff;
      len_in    = len_ff;

      case (mode_ff)
         MODE_SLASH: begin
            if (ch == CH_SLASH) begin
               mode_in = MODE_LCOM;
            end else if (ch == CH_STAR) begin
               mode_in = MODE_BCOM;
            end else begin
               pre_v    = 1'b1;
               pre_kind = KIND_INVALID;
               pre_len  = LEN_BITS'(1);
               mode_in  = MODE_ERR;
               if (ch == CH_NUL) begin
                  eof    = 1'b1;
                  post_v = 1'b1;
               end else begin
                  bump = (ch == CH_NL);
               end
            end
         end
         MODE_LCOM: begin
            if (ch == CH_NUL) begin
               eof    = 1'b1;
               post_v = 1'b1;
            end else if (ch == CH_NL) begin
               bump    = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_BCOM, MODE_BSTAR: begin
            if (ch == CH_NUL) begin
               eof    = 1'b1;
               post_v = 1'b1;
            end else if (mode_ff == MODE_BSTAR && ch == CH_SLASH) begin
               mode_in = MODE_IDLE;
            end else if (ch == CH_STAR) begin
               mode_in = MODE_BSTAR;
            end else begin
               bump    = (ch == CH_NL);
               mode_in = MODE_BCOM;
            end
         end
         MODE_MINUS: begin
            pre_v = 1'b1;
            if (ch == CH_MINUS) begin
               pre_kind = KIND_DECR;
               pre_len  = LEN_BITS'(2);
               mode_in  = MODE_IDLE;
            end else begin
               pre_kind = KIND_NEG;
               pre_len  = LEN_BITS'(1);
               use_idle = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_letter(ch) || is_digit(ch)) begin
               if (len_ff < LEN_BITS'(KW_CHARS)) begin
                  kw_in = kw_ff | (KW_BITS'(ch) << {len_ff[2:0], 3'b000});
               end
               len_in = sat_inc(len_ff);
            end else begin
               pre_v    = 1'b1;
               pre_kind = ident_kind;
               use_idle = 1'b1;
            end
         end
         MODE_NUM: begin
            if (is_digit(ch)) begin
               len_in = sat_inc(len_ff);
            end else if (is_letter(ch)) begin
               pre_v    = 1'b1;
               pre_kind = KIND_INVALID;
               pre_len  = sat_inc(len_ff);
               mode_in  = MODE_ERR;
            end else begin
               pre_v    = 1'b1;
               pre_kind = KIND_NUM;
               use_idle = 1'b1;
            end
         end
         MODE_ERR: begin
            if (ch == CH_NUL) begin
               eof    = 1'b1;
               post_v = 1'b1;
            end else begin
               bump = (ch == CH_NL);
            end
         end
         default: begin
            use_idle = 1'b1;
         end
      endcase

      // Apply the between-tokens outcome of this byte
      if (use_idle) begin
         mode_in   = idle.nmode;
         bump      = idle.bump;
         eof       = idle.eof;
         post_v    = idle.tok_v;
         post_kind = idle.kind;
         post_len  = idle.eof ? '0 : LEN_BITS'(1);
         if (idle.start) begin
            start_in = offset_ff;
            len_in   = LEN_BITS'(1);
         end
         if (idle.load_kw) begin
            kw_in = KW_BITS'(ch);
         end
      end

      // End of text restarts everything but the token queue
      if (eof) begin
         mode_in   = MODE_IDLE;
         kw_in     = '0;
         start_in  = '0;
         len_in    = '0;
         line_in   = LINE_BITS'(1);
         offset_in = '0;
      end else begin
         line_in   = (bump && line_ff != LINE_MAX) ? line_ff + LINE_BITS'(1) : line_ff;
         offset_in = offset_ff + OFFSET_BITS'(1);
      end
   end

   // Pack tokens: the earlier one always lands in slot zero
   always_comb begin
      tok0_valid = pre_v || post_v;
      tok1_valid = pre_v && post_v;

      tok0.kind         = pre_v ? pre_kind : post_kind;
      tok0.line_no      = line_ff;
      tok0.start_offset = pre_v ? start_ff : offset_ff;
      tok0.tok_len      = pre_v ? pre_len : post_len;
      tok0.last         = !tok1_valid;

      tok1.kind         = post_kind;
      tok1.line_no      = line_ff;
      tok1.start_offset = offset_ff;
      tok1.tok_len      = post_len;
      tok1.last         = 1'b1;
   end

   // Advance the lexer state on each consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         kw_ff     <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         line_ff   <= LINE_BITS'(1);
         offset_ff <= '0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         kw_ff     <= kw_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         line_ff   <= line_in;
         offset_ff <= offset_in;
      end
   end

endmodule

// ===== rtl/core/csl_fifo.sv =====
// Small token queue that takes up to two tokens and gives one per cycle while pop is high.
module csl_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push0,
   input  logic                            push1,
   input  csl_pkg::token_type              din0,
   input  csl_pkg::token_type              din1,
   input  logic                            pop,
   output csl_pkg::token_type              dout,
   output logic [csl_pkg::CNT_BITS-1:0]    count
);
   import csl_pkg::*;

   token_type             mem_ff [FIFO_DEPTH];
   token_type             mem_in [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ff, wr_in;
   logic [PTR_BITS-1:0]   rd_ff, rd_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_next;

   // Write one or two entries at the tail
   always_comb begin
      wr_next = wr_ff + PTR_BITS'(1);
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         mem_in[i] = mem_ff[i];
      end
      if (push0) begin
         mem_in[wr_ff] = din0;
      end
      if (push1) begin
         mem_in[wr_next] = din1;
      end
      wr_in    = wr_ff + PTR_BITS'(push0) + PTR_BITS'(push1);
      rd_in    = rd_ff + PTR_BITS'(pop);
      count_in = count_ff + CNT_BITS'(push0) + CNT_BITS'(push1) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         mem_ff[i] <= mem_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   assign dout  = mem_ff[rd_ff];
   assign count = count_ff;

endmodule

// ===== dv/tb_c_subset_lexer.sv =====
// Self-checking stream testbench for the C subset lexer: byte stimulus, token prediction, checks.
module tb_c_subset_lexer;
   import csl_pkg::*;

   localparam int CLOCK_LIMIT = 50000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int IDLE_PERCENT = 17;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_VT  = 8'h0B;
   localparam logic [7:0] CH_FF  = 8'h0C;
   localparam logic [7:0] CH_CR  = 8'h0D;

   localparam logic [KW_BITS-1:0] KW_INT    = 48'h0000_0074_6E69;
   localparam logic [KW_BITS-1:0] KW_VOID   = 48'h0000_6469_6F76;
   localparam logic [KW_BITS-1:0] KW_RETURN = 48'h6E72_7574_6572;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [CH_BITS-1:0]       req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [KIND_BITS-1:0]     rsp_tuser;
   logic                     rsp_tlast;

   // Stimulus control
   logic        idle_en = 1'b0;
   logic        rsp_hold = 1'b0;
   event        rsp_hold_start;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned failures = 0;

   // Lexer shadow state
   mode_type               lx_mode = MODE_IDLE;
   logic [KW_BITS-1:0]     lx_kw = '0;
   logic [OFFSET_BITS-1:0] lx_start = '0;
   logic [LEN_BITS-1:0]    lx_len = '0;
   logic [LINE_BITS-1:0]   lx_line = LINE_BITS'(1);
   logic [OFFSET_BITS-1:0] lx_offset = '0;
   logic                   lx_eof = 1'b0;

   token_type   byte_tokens[$];
   token_type   expected_tokens[$];
   logic [7:0]  src_text[$];

   c_subset_lexer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- token prediction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == " " || c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF || c == CH_CR;
   endfunction

   function automatic void bump_line();
      if (lx_line != {LINE_BITS{1'b1}}) lx_line = lx_line + 1'b1;
   endfunction

   function automatic logic [LEN_BITS-1:0] sat_len(logic [LEN_BITS:0] len);
      return len[LEN_BITS] ? {LEN_BITS{1'b1}} : len[LEN_BITS-1:0];
   endfunction

   function automatic void emit_token(kind_type k, logic [OFFSET_BITS-1:0] start,
                                      logic [LEN_BITS:0] len);
      token_type t;
      t.kind = k;
      t.line_no = lx_line;
      t.start_offset = start;
      t.tok_len = sat_len(len);
      t.last = 1'b0;
      byte_tokens.push_back(t);
   endfunction

   // Close the text: Eof at the zero byte, then restart line and token state
   function automatic void end_text();
      emit_token(KIND_EOF, lx_offset, '0);
      lx_line = LINE_BITS'(1);
      lx_mode = MODE_IDLE;
      lx_kw = '0;
      lx_start = '0;
      lx_len = '0;
      lx_eof = 1'b1;
   endfunction

   function automatic void scan_idle(logic [7:0] c);
      kind_type k;
      logic     punct;
      punct = 1'b1;
      lx_mode = MODE_IDLE;
      case (c)
         "=":     k = KIND_ASSIGN;
         "~":     k = KIND_BCOM;
         "{":     k = KIND_LBRACE;
         "(":     k = KIND_LPAREN;
         "}":     k = KIND_RBRACE;
         ")":     k = KIND_RPAREN;
         ";":     k = KIND_SEMI;
         default: begin
            k = KIND_EOF;
            punct = 1'b0;
         end
      endcase
      if (c == CH_NUL) begin
         end_text();
      end else if (is_blank(c)) begin
         if (c == CH_NL) bump_line();
      end else if (punct) begin
         emit_token(k, lx_offset, (LEN_BITS+1)'(1));
      end else begin
         lx_start = lx_offset;
         lx_len = LEN_BITS'(1);
         if (c == "/") begin
            lx_mode = MODE_SLASH;
         end else if (c == "-") begin
            lx_mode = MODE_MINUS;
         end else if (is_digit(c)) begin
            lx_mode = MODE_NUM;
         end else if (is_letter(c)) begin
            lx_mode = MODE_IDENT;
            lx_kw = KW_BITS'(c);
         end else begin
            lx_mode = MODE_ERR;
            emit_token(KIND_INVALID, lx_offset, (LEN_BITS+1)'(1));
         end
      end
   endfunction

   function automatic kind_type word_kind();
      if (lx_len == 3 && lx_kw == KW_INT) return KIND_INT;
      if (lx_len == 4 && lx_kw == KW_VOID) return KIND_VOID;
      if (lx_len == 6 && lx_kw == KW_RETURN) return KIND_RETURN;
      return KIND_ID;
   endfunction

   // Advance the shadow lexer by one byte and queue the tokens it releases
   function automatic void predict_byte(logic [7:0] c);
      byte_tokens.delete();
      lx_eof = 1'b0;
      case (lx_mode)
         MODE_SLASH: begin
            if (c == "/") begin
               lx_mode = MODE_LCOM;
            end else if (c == "*") begin
               lx_mode = MODE_BCOM;
            end else begin
               emit_token(KIND_INVALID, lx_start, (LEN_BITS+1)'(1));
               lx_mode = MODE_ERR;
               if (c == CH_NUL) end_text();
               else if (c == CH_NL) bump_line();
            end
         end
         MODE_LCOM: begin
            if (c == CH_NUL) begin
               end_text();
            end else if (c == CH_NL) begin
               bump_line();
               lx_mode = MODE_IDLE;
            end
         end
         MODE_BCOM, MODE_BSTAR: begin
            if (c == CH_NUL) begin
               end_text();
            end else if (lx_mode == MODE_BSTAR && c == "/") begin
               lx_mode = MODE_IDLE;
            end else if (c == "*") begin
               lx_mode = MODE_BSTAR;
            end else begin
               if (c == CH_NL) bump_line();
               lx_mode = MODE_BCOM;
            end
         end
         MODE_MINUS: begin
            if (c == "-") begin
               emit_token(KIND_DECR, lx_start, (LEN_BITS+1)'(2));
               lx_mode = MODE_IDLE;
            end else begin
               emit_token(KIND_NEG, lx_start, (LEN_BITS+1)'(1));
               scan_idle(c);
            end
         end
         MODE_IDENT: begin
            if (is_letter(c) || is_digit(c)) begin
               if (lx_len < 6) lx_kw = lx_kw | (KW_BITS'(c) << (8 * lx_len));
               lx_len = sat_len({1'b0, lx_len} + 1'b1);
            end else begin
               emit_token(word_kind(), lx_start, {1'b0, lx_len});
               scan_idle(c);
            end
         end
         MODE_NUM: begin
            if (is_digit(c)) begin
               lx_len = sat_len({1'b0, lx_len} + 1'b1);
            end else if (is_letter(c)) begin
               emit_token(KIND_INVALID, lx_start, {1'b0, lx_len} + 1'b1);
               lx_mode = MODE_ERR;
            end else begin
               emit_token(KIND_NUM, lx_start, {1'b0, lx_len});
               scan_idle(c);
            end
         end
         MODE_ERR: begin
            if (c == CH_NUL) end_text();
            else if (c == CH_NL) bump_line();
         end
         default: scan_idle(c);
      endcase
      if (lx_eof) lx_offset = '0;
      else lx_offset = lx_offset + 1'b1;
      for (int i = 0; i < byte_tokens.size(); i++) begin
         if (i == byte_tokens.size() - 1) byte_tokens[i].last = 1'b1;
         expected_tokens.push_back(byte_tokens[i]);
      end
   endfunction

   // ---------------------------------------------------------------- source side

   // Offer one byte, idling at random first, and predict once it transfers
   task automatic send_byte(input logic [7:0] c);
      while (idle_en && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_byte(c);
   endtask

   task automatic send_src();
      foreach (src_text[i]) send_byte(src_text[i]);
      src_text.delete();
   endtask

   function automatic void add_byte(logic [7:0] c);
      src_text.push_back(c);
   endfunction

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
   endfunction

   function automatic logic [7:0] pick_letter();
      int unsigned r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] pick_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 5))
         0:       return " ";
         1:       return CH_TAB;
         2:       return CH_NL;
         3:       return CH_VT;
         4:       return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   // Comment body: any nonzero byte, with stars mixed in and newlines in block comments only
   function automatic void add_comment_body(logic line_comment);
      logic [7:0] c;
      repeat ($urandom_range(0, 10)) begin
         case ($urandom_range(0, 3))
            0:       c = "*";
            1:       c = CH_NL;
            default: c = 8'($urandom_range(1, 255));
         endcase
         if (line_comment && c == CH_NL) c = "x";
         add_byte(c);
      end
   endfunction

   function automatic void add_random_piece();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         case ($urandom_range(0, 2))
            0:       add_str("int");
            1:       add_str("void");
            default: add_str("return");
         endcase
      end else if (pick < 20) begin
         case ($urandom_range(0, 8))
            0:       add_str("in");
            1:       add_str("intx");
            2:       add_str("voi");
            3:       add_str("voids");
            4:       add_str("retur");
            5:       add_str("return_");
            6:       add_str("Int");
            7:       add_str("returned");
            default: add_str("void9");
         endcase
      end else if (pick < 32) begin
         add_byte(pick_letter());
         repeat ($urandom_range(0, 7)) begin
            if ($urandom_range(0, 3) == 0) add_byte(pick_digit());
            else add_byte(pick_letter());
         end
      end else if (pick < 42) begin
         repeat ($urandom_range(1, 5)) add_byte(pick_digit());
      end else if (pick < 58) begin
         case ($urandom_range(0, 6))
            0:       add_str("=");
            1:       add_str("~");
            2:       add_str("{");
            3:       add_str("(");
            4:       add_str("}");
            5:       add_str(")");
            default: add_str(";");
         endcase
      end else if (pick < 66) begin
         case ($urandom_range(0, 2))
            0:       add_str("-");
            1:       add_str("--");
            default: add_str("---");
         endcase
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 3)) add_byte(pick_blank());
      end else if (pick < 86) begin
         add_str("//");
         add_comment_body(1'b1);
         add_byte(CH_NL);
      end else if (pick < 92) begin
         add_str("/*");
         add_comment_body(1'b0);
         add_str("*/");
      end else begin
         // Malformed input: stray bytes, lone slash, number running into a letter
         case ($urandom_range(0, 3))
            0: add_byte(8'($urandom_range(1, 255)));
            1: add_byte(8'($urandom_range(128, 255)));
            2: begin
               add_byte("/");
               case ($urandom_range(0, 3))
                  0:       add_byte("x");
                  1:       add_byte(CH_NL);
                  2:       add_byte(" ");
                  default: add_byte("=");
               endcase
            end
            default: begin
               repeat ($urandom_range(1, 3)) add_byte(pick_digit());
               add_byte(pick_letter());
            end
         endcase
      end
   endfunction

   // Build one text of random tokens, ending in the zero byte
   function automatic void build_random_text();
      int unsigned tail;
      repeat ($urandom_range(1, 20)) begin
         add_random_piece();
         if ($urandom_range(0, 9) < 4) add_byte(pick_blank());
      end
      tail = $urandom_range(0, 99);
      if (tail < 4) begin
         add_str("/*");
         add_comment_body(1'b0);
      end else if (tail < 8) begin
         add_str("//");
         add_comment_body(1'b1);
      end
      add_byte(CH_NUL);
   endfunction

   // ---------------------------------------------------------------- result side

   // Hold off the result channel after each rsp_hold_start event
   always begin
      @(rsp_hold_start);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Compare each token transfer with the oldest prediction, then pick next ready
   always @(posedge clock) begin
      token_type want;
      token_type got;
      logic [RSP_DATA_BITS-1:0] fill;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = kind_type'(rsp_tuser);
         got.line_no = rsp_tdata[LINE_BITS-1:0];
         got.start_offset = rsp_tdata[LINE_BITS +: OFFSET_BITS];
         got.tok_len = rsp_tdata[LINE_BITS+OFFSET_BITS +: LEN_BITS];
         got.last = rsp_tlast;
         fill = rsp_tdata >> PAYLOAD_BITS;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token kind %0d line %0d offset %0d len %0d last %0d",
                     $time, got.kind, got.line_no, got.start_offset, got.tok_len, got.last);
            failures++;
         end else begin
            want = expected_tokens.pop_front();
            if (got !== want || fill !== '0) begin
               $display({"%0t: token mismatch: expected kind %0d line %0d offset %0d",
                         " len %0d last %0d"},
                        $time, want.kind, want.line_no, want.start_offset, want.tok_len,
                        want.last);
               $display({"%0t:                 actual kind %0d line %0d offset %0d",
                         " len %0d last %0d fill %0h"},
                        $time, got.kind, got.line_no, got.start_offset, got.tok_len, got.last,
                        fill);
               failures++;
            end
         end
      end
      rsp_tready <= !rsp_hold && !(idle_en && $urandom_range(99) < IDLE_PERCENT);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CLOCK_LIMIT) begin
         $display("%0t: timeout with %0d tokens outstanding", $time, expected_tokens.size());
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // Every punctuation token, keyword ends, the special cases of slash, minus and numbers
   task automatic test_directed_tokens();
      idle_en <= 1'b1;
      add_str("int=~{(});--x-");
      add_byte(CH_NUL);
      add_str("/");
      add_byte(CH_NUL);
      add_str("9z");
      add_byte(8'hFF);
      add_byte(CH_NL);
      add_byte(CH_NUL);
      send_src();
   endtask

   // Saturate token length for an identifier, a number and a number running into a letter
   task automatic test_length_saturation();
      idle_en <= 1'b0;
      repeat (300) add_byte(pick_letter());
      add_str(";");
      repeat (260) add_byte(pick_digit());
      add_str(" ");
      repeat (258) add_byte(pick_digit());
      add_str("q");
      add_byte(CH_NUL);
      send_src();
   endtask

   // Advance the line count over many newlines, then check that Eof restarts it
   task automatic test_line_restart();
      idle_en <= 1'b0;
      repeat (40) send_byte(CH_NL);
      add_str("x;");
      add_byte(CH_NUL);
      add_str("void");
      add_byte(CH_NUL);
      send_src();
   endtask

   // Stall the result side long enough to fill the token queue and block input
   task automatic test_backpressure();
      idle_en <= 1'b0;
      -> rsp_hold_start;
      repeat (30) add_str("a;");
      add_byte(CH_NUL);
      send_src();
   endtask

   task automatic test_random_texts(input int unsigned target, input logic with_idle);
      int unsigned base;
      base = items_sent;
      idle_en <= with_idle;
      while (items_sent - base < target) begin
         build_random_text();
         send_src();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_tokens();
      test_length_saturation();
      test_line_restart();
      test_backpressure();
      test_random_texts(200, 1'b0);
      test_random_texts(550, 1'b1);
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/csl_pkg.sv
rtl/core/csl_scan.sv
rtl/core/csl_fifo.sv
rtl/core/c_subset_lexer.sv
dv/tb_c_subset_lexer.sv
